>>> sv/mfs_pkg.sv
// mfs_pkg: shared types and constants for the motor fault supervisor.
// Beat layouts, register indexes, reset values and flag bit positions.
// No dependencies.
`default_nettype none

package mfs_pkg;

    // item kind, carried on the slave tuser
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_OC_LIMIT   = 3'd0,
        REG_OC_HOLD    = 3'd1,
        REG_UV_LIMIT   = 3'd2,
        REG_OT_LIMIT   = 3'd3,
        REG_LINK_TMO   = 3'd4,
        REG_STALL_LIM  = 3'd5,
        REG_STALL_HOLD = 3'd6,
        REG_SPARE      = 3'd7
    } t_reg_idx;

    localparam int unsigned CFG_W     = 18;
    localparam int unsigned FLAG_W    = 6;
    localparam int unsigned TIMER_W   = 17;

    // register reset values
    localparam logic [15:0] RST_OC_LIMIT   = 16'd5000;
    localparam logic [15:0] RST_OC_HOLD    = 16'd100;
    localparam logic [15:0] RST_UV_LIMIT   = 16'd10000;
    localparam logic [17:0] RST_OT_LIMIT   = 18'sd85000;
    localparam logic [15:0] RST_LINK_TMO   = 16'd500;
    localparam logic [15:0] RST_STALL_LIM  = 16'd3000;
    localparam logic [15:0] RST_STALL_HOLD = 16'd1000;

    // flag bit positions
    localparam int unsigned F_SENSOR   = 0;
    localparam int unsigned F_OVERCUR  = 1;
    localparam int unsigned F_UNDERV   = 2;
    localparam int unsigned F_OVERTEMP = 3;
    localparam int unsigned F_LINK     = 4;
    localparam int unsigned F_STALL    = 5;

    // slave tdata layout (lowest bit first)
    localparam int unsigned IN_CUR_OK  = 0;
    localparam int unsigned IN_VOLT_OK = 1;
    localparam int unsigned IN_TEMP_OK = 2;
    localparam int unsigned IN_CUR_LO  = 3;
    localparam int unsigned IN_SUP_LO  = 19;
    localparam int unsigned IN_TMP_LO  = 35;
    localparam int unsigned IN_DUTY_LO = 53;
    localparam int unsigned IN_AGE_LO  = 63;
    localparam int unsigned IN_DT_LO   = 95;
    localparam int unsigned IN_MASK_LO = 111;
    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_DATA_W = 16;

endpackage

`default_nettype wire

>>> sv/motor_fault_supervisor.sv
// motor_fault_supervisor: top level of the motor drive fault supervisor.
// Depends on mfs_pkg for beat layouts, register indexes and reset values.
//
// Usage:
//   Slave stream (s_axis_*) takes one item per beat. tuser is the item kind:
//   update (measurements) or clear (remove masked latched flags).
//   Master stream (m_axis_*) returns exactly one result beat per item:
//   latched flags after the item and the flags raised by it (zero on clear).
//   Flag order: sensor, overcurrent, undervoltage, overtemp, link, stall.
//   Configuration: i_cfg_we/i_cfg_index/i_cfg_wdata, written while idle.
// An accepted slave beat lands in the input register at the accepting edge;
//   one pass of compares and saturating timer adds then loads the result
//   register, which also updates timers and latched set, and master tvalid
//   rises as the result register fills.
// Throughput: one item per cycle while the master side takes beats; the
//   single pass from input register to result register sets that figure.
// Stall: if m_axis_tready is low the result register holds; if the input
//   register is empty, one more item is taken into it, then s_axis_tready drops.
// Reset (synchronous, i_rst_n low): both stages empty, timers and latched
//   set zero, configuration registers back to their defaults.
`default_nettype none

module motor_fault_supervisor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave stream
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // cur_ok, volt_ok, temp_ok, current_ma[16], supply_mv[16],
    // board_temp_mc[18], duty[10], link_age_ms[32], elapsed_ms[16],
    // clr_bits[6], zero pad[3]
    input  wire logic [mfs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op (0 update, 1 clear)
    input  wire logic                          s_axis_tuser,
    // master stream
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // latched_faults[6], active_faults[6], zero pad[4]
    output      logic [mfs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [mfs_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int unsigned FW = mfs_pkg::FLAG_W;
    localparam int unsigned TW = mfs_pkg::TIMER_W;

    // configuration
    logic [15:0]        r_oc_limit, r_oc_hold, r_uv_limit, r_link_tmo;
    logic [15:0]        r_stall_lim, r_stall_hold;
    logic signed [17:0] r_ot_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_limit   <= mfs_pkg::RST_OC_LIMIT;
            r_oc_hold    <= mfs_pkg::RST_OC_HOLD;
            r_uv_limit   <= mfs_pkg::RST_UV_LIMIT;
            r_ot_limit   <= mfs_pkg::RST_OT_LIMIT;
            r_link_tmo   <= mfs_pkg::RST_LINK_TMO;
            r_stall_lim  <= mfs_pkg::RST_STALL_LIM;
            r_stall_hold <= mfs_pkg::RST_STALL_HOLD;
        end else if (i_cfg_we) begin
            unique case (mfs_pkg::t_reg_idx'(i_cfg_index))
                mfs_pkg::REG_OC_LIMIT:   r_oc_limit   <= i_cfg_wdata[15:0];
                mfs_pkg::REG_OC_HOLD:    r_oc_hold    <= i_cfg_wdata[15:0];
                mfs_pkg::REG_UV_LIMIT:   r_uv_limit   <= i_cfg_wdata[15:0];
                mfs_pkg::REG_OT_LIMIT:   r_ot_limit   <= i_cfg_wdata;
                mfs_pkg::REG_LINK_TMO:   r_link_tmo   <= i_cfg_wdata[15:0];
                mfs_pkg::REG_STALL_LIM:  r_stall_lim  <= i_cfg_wdata[15:0];
                mfs_pkg::REG_STALL_HOLD: r_stall_hold <= i_cfg_wdata[15:0];
                default: ;  // spare index: ignored
            endcase
        end
    end

    // handshake
    logic                          r_in_valid, r_out_valid;
    logic [mfs_pkg::IN_DATA_W-1:0] r_in_data;
    logic                          r_in_op;
    logic                          w_advance, w_fire;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    // field unpack
    logic               w_cur_ok, w_volt_ok, w_temp_ok;
    logic [15:0]        w_current, w_supply, w_dt;
    logic signed [17:0] w_temp;
    logic [9:0]         w_duty;
    logic [31:0]        w_age;
    logic [FW-1:0]      w_mask;

    assign w_cur_ok  = r_in_data[mfs_pkg::IN_CUR_OK];
    assign w_volt_ok = r_in_data[mfs_pkg::IN_VOLT_OK];
    assign w_temp_ok = r_in_data[mfs_pkg::IN_TEMP_OK];
    assign w_current = r_in_data[mfs_pkg::IN_CUR_LO  +: 16];
    assign w_supply  = r_in_data[mfs_pkg::IN_SUP_LO  +: 16];
    assign w_temp    = r_in_data[mfs_pkg::IN_TMP_LO  +: 18];
    assign w_duty    = r_in_data[mfs_pkg::IN_DUTY_LO +: 10];
    assign w_age     = r_in_data[mfs_pkg::IN_AGE_LO  +: 32];
    assign w_dt      = r_in_data[mfs_pkg::IN_DT_LO   +: 16];
    assign w_mask    = r_in_data[mfs_pkg::IN_MASK_LO +: FW];

    // state
    logic [FW-1:0] r_latched, r_out_latched, r_out_active;
    logic [TW-1:0] r_oc_elapsed, r_stall_elapsed;

    // persistence timers: add elapsed time, saturate, drop to zero off condition
    logic          w_oc_cond, w_stall_cond;
    logic [TW:0]   w_oc_sum, w_stall_sum;
    logic [TW-1:0] n_oc_elapsed, n_stall_elapsed;
    logic [FW-1:0] w_active, n_latched;

    always_comb begin
        w_oc_cond    = w_current > r_oc_limit;
        w_stall_cond = (w_duty != 10'd0) && (w_current > r_stall_lim);
        w_oc_sum     = {1'b0, r_oc_elapsed}    + (TW+1)'(w_dt);
        w_stall_sum  = {1'b0, r_stall_elapsed} + (TW+1)'(w_dt);

        n_oc_elapsed    = '0;
        n_stall_elapsed = '0;
        if (w_oc_cond) begin
            n_oc_elapsed = w_oc_sum[TW] ? '1 : w_oc_sum[TW-1:0];
        end
        if (w_stall_cond) begin
            n_stall_elapsed = w_stall_sum[TW] ? '1 : w_stall_sum[TW-1:0];
        end

        w_active = '0;
        w_active[mfs_pkg::F_SENSOR]   = !(w_cur_ok && w_volt_ok && w_temp_ok);
        w_active[mfs_pkg::F_OVERCUR]  = w_oc_cond && (n_oc_elapsed >= TW'(r_oc_hold));
        w_active[mfs_pkg::F_UNDERV]   = w_supply < r_uv_limit;
        w_active[mfs_pkg::F_OVERTEMP] = w_temp > r_ot_limit;
        w_active[mfs_pkg::F_LINK]     = w_age > 32'(r_link_tmo);
        w_active[mfs_pkg::F_STALL]    = w_stall_cond
                                        && (n_stall_elapsed >= TW'(r_stall_hold));

        if (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_CLEAR) begin
            n_latched = r_latched & ~w_mask;
        end else begin
            n_latched = r_latched | w_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_latched       <= '0;
            r_oc_elapsed    <= '0;
            r_stall_elapsed <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_latched <= n_latched;
                if (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_UPDATE) begin
                    r_oc_elapsed    <= n_oc_elapsed;
                    r_stall_elapsed <= n_stall_elapsed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_latched <= n_latched;
            r_out_active  <= (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_CLEAR)
                             ? '0 : w_active;
        end
    end

    assign m_axis_tdata = {(mfs_pkg::OUT_DATA_W - 2*FW)'(0), r_out_active, r_out_latched};

`ifndef ASSERT_OFF
    // every flag raised in a result is also in its latched set
    a_active_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_latched & r_out_active) == r_out_active))
        else $error("active flag missing from latched set");

    // an update never drops a latched bit
    a_update_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_UPDATE))
        |=> ((r_latched & $past(r_latched)) == $past(r_latched)))
        else $error("update lost a latched flag");

    // overcurrent timer restarts when current drops to the limit
    a_oc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_UPDATE) && !w_oc_cond)
        |=> (r_oc_elapsed == '0))
        else $error("overcurrent timer not restarted");

    // a clear leaves both timers alone
    a_clear_timers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (mfs_pkg::t_op'(r_in_op) == mfs_pkg::OP_CLEAR))
        |=> ($stable(r_oc_elapsed) && $stable(r_stall_elapsed)))
        else $error("clear moved a timer");

    // a full input register facing a stalled result blocks the slave side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("slave ready while both stages full");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking bench for motor_fault_supervisor, driven over its stream ports.
// Predicts latched and active fault flags per beat and checks every result beat.
// Depends on mfs_pkg and the motor_fault_supervisor RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mfs_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int HOLD_OFF    = 80;    // long master-side stall, in cycles

    // one slave beat, field by field
    typedef struct {
        t_op                op;
        logic               cur_ok;
        logic               volt_ok;
        logic               temp_ok;
        logic [15:0]        current;
        logic [15:0]        supply;
        logic signed [17:0] temp;
        logic [9:0]         duty;
        logic [31:0]        age;
        logic [15:0]        dt;
        logic [5:0]         mask;
    } fault_item_t;

    typedef struct {
        logic [5:0] latched;
        logic [5:0] active;
    } t_result_flags;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [2:0]              i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;

    motor_fault_supervisor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers, timers and latched set.
    // ------------------------------------------------------------------
    logic [15:0]        oc_limit;
    logic [15:0]        oc_hold;
    logic [15:0]        uv_limit;
    logic signed [17:0] ot_limit;
    logic [15:0]        link_tmo;
    logic [15:0]        stall_limit;
    logic [15:0]        stall_hold;

    logic [5:0]         latched_flags;
    logic [16:0]        oc_timer;
    logic [16:0]        stall_timer;

    fault_item_t        supervisor_beats[$];  // waiting to be offered
    t_result_flags      flags_due[$];         // predicted, not yet seen
    fault_item_t        on_bus;               // beat currently offered

    int                 mismatches = 0;
    int                 beats_sent = 0;
    int                 results_seen = 0;

    function automatic logic [16:0] timer_add(logic [16:0] t, logic [15:0] dt);
        logic [17:0] sum;
        sum = {1'b0, t} + {2'b00, dt};
        return sum[17] ? 17'h1FFFF : sum[16:0];
    endfunction

    // Advances the predicted state by one accepted beat and returns its flags.
    function automatic t_result_flags supervise(fault_item_t it);
        t_result_flags r;
        logic [5:0]    act;
        act = '0;
        if (it.op == OP_CLEAR) begin
            // measurements ignored, timers untouched
            latched_flags = latched_flags & ~it.mask;
        end else begin
            if (!it.cur_ok || !it.volt_ok || !it.temp_ok)
                act[F_SENSOR] = 1'b1;
            if (it.current > oc_limit) begin
                oc_timer = timer_add(oc_timer, it.dt);
                if (oc_timer >= {1'b0, oc_hold})
                    act[F_OVERCUR] = 1'b1;
            end else begin
                oc_timer = '0;
            end
            if (it.supply < uv_limit)
                act[F_UNDERV] = 1'b1;
            if (it.temp > ot_limit)
                act[F_OVERTEMP] = 1'b1;
            if (it.age > {16'h0, link_tmo})
                act[F_LINK] = 1'b1;
            // any nonzero duty counts, including codes above 1000
            if (it.duty != 0 && it.current > stall_limit) begin
                stall_timer = timer_add(stall_timer, it.dt);
                if (stall_timer >= {1'b0, stall_hold})
                    act[F_STALL] = 1'b1;
            end else begin
                stall_timer = '0;
            end
            latched_flags = latched_flags | act;
        end
        r.latched = latched_flags;
        r.active  = act;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_beat(fault_item_t it);
        return {3'b000, it.mask, it.dt, it.age, it.duty, it.temp, it.supply, it.current,
                it.temp_ok, it.volt_ok, it.cur_ok};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] near16(logic [15:0] centre);
        int v;
        v = int'(centre) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    function automatic fault_item_t update_item(logic [15:0] cur, logic [15:0] sup,
                                                int tmp, logic [9:0] duty,
                                                logic [31:0] age, logic [15:0] dt);
        fault_item_t it;
        it.op      = OP_UPDATE;
        it.cur_ok  = 1'b1;
        it.volt_ok = 1'b1;
        it.temp_ok = 1'b1;
        it.current = cur;
        it.supply  = sup;
        it.temp    = 18'(tmp);
        it.duty    = duty;
        it.age     = age;
        it.dt      = dt;
        it.mask    = 6'($urandom);  // must be ignored on an update
        return it;
    endfunction

    function automatic fault_item_t clear_item(logic [5:0] mask);
        fault_item_t it;
        // measurement fields carry junk; the block must ignore them
        it = update_item(16'($urandom), 16'($urandom), int'(18'($urandom)),
                         10'($urandom), $urandom, 16'($urandom));
        it.op      = OP_CLEAR;
        it.cur_ok  = 1'($urandom);
        it.volt_ok = 1'($urandom);
        it.temp_ok = 1'($urandom);
        it.mask    = mask;
        return it;
    endfunction

    // Random beat biased towards the current, supply, temperature and link thresholds
    // so the persistence timers build runs and flags toggle; the rest is full-range noise.
    function automatic fault_item_t random_item();
        fault_item_t it;
        int          pick;
        int          t;
        longint      a;
        logic [15:0] hi;
        if ($urandom_range(99) < 10)
            return clear_item(6'($urandom));
        it = update_item(0, 0, 0, 0, 0, 0);
        it.cur_ok  = $urandom_range(99) >= 6;
        it.volt_ok = $urandom_range(99) >= 6;
        it.temp_ok = $urandom_range(99) >= 6;
        pick = $urandom_range(99);
        hi = (oc_limit > stall_limit) ? oc_limit : stall_limit;
        if (pick < 40)      it.current = near16(oc_limit);
        else if (pick < 65) it.current = near16(stall_limit);
        else if (pick < 80) it.current = 16'($urandom_range(65535, int'(hi)));
        else                it.current = 16'($urandom);
        it.supply = $urandom_range(1) ? near16(uv_limit) : 16'($urandom);
        if ($urandom_range(1)) begin
            t = int'(ot_limit) + int'($urandom_range(8)) - 4;
            if (t < -131072) t = -131072;
            if (t > 131071)  t = 131071;
            it.temp = 18'(t);
        end else begin
            it.temp = 18'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 15)      it.duty = '0;
        else if (pick < 25) it.duty = 10'($urandom_range(1023, 1001));
        else                it.duty = 10'($urandom);
        if ($urandom_range(1)) begin
            a = longint'(link_tmo) + longint'($urandom_range(8)) - 4;
            if (a < 0) a = 0;
            it.age = 32'(a);
        end else begin
            it.age = $urandom;
        end
        it.dt = ($urandom_range(99) < 75) ? 16'($urandom_range(40)) : 16'($urandom);
        return it;
    endfunction

    // Register write, only ever issued with the block idle.
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_OC_LIMIT:   oc_limit    = val[15:0];
            REG_OC_HOLD:    oc_hold     = val[15:0];
            REG_UV_LIMIT:   uv_limit    = val[15:0];
            REG_OT_LIMIT:   ot_limit    = val;
            REG_LINK_TMO:   link_tmo    = val[15:0];
            REG_STALL_LIM:  stall_limit = val[15:0];
            REG_STALL_HOLD: stall_hold  = val[15:0];
            default: ;  // spare index: write dropped
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender holds back until every predicted beat has come out.
    task automatic drain();
        do @(negedge i_clk);
        while (supervisor_beats.size() != 0 || s_axis_tvalid || flags_due.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) supervisor_beats.push_back(random_item());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued beats, predicts each one on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                flags_due.push_back(supervise(on_bus));
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // no idling while in the calm window
                if (supervisor_beats.size() != 0 &&
                    ((beats_sent >= 800 && beats_sent < 1050) ||
                     $urandom_range(99) >= 17)) begin
                    on_bus = supervisor_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_beat(on_bus);
                    s_axis_tuser  <= on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats, stalls at random, one long hold-off.
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge i_clk) begin
        t_result_flags want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (flags_due.size() == 0) begin
                    $error("result beat with nothing predicted: tdata=%h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = flags_due.pop_front();
                    if (m_axis_tdata[5:0] !== want.latched) begin
                        $error("latched_faults: expected %b, got %b",
                               want.latched, m_axis_tdata[5:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[11:6] !== want.active) begin
                        $error("active_faults: expected %b, got %b",
                               want.active, m_axis_tdata[11:6]);
                        mismatches++;
                    end
                end
            end
            // long hold-off mid-run lets the input register fill and
            // forces s_axis_tready low while the sender keeps offering
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!held_once && results_seen >= 350) begin
                held_once = 1'b1;
                hold_left = HOLD_OFF;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (results_seen >= 800 && results_seen < 1050) ||
                                 ($urandom_range(99) >= 17);
            end
        end
    end

    // Watchdog: a run with no beat moving for too long is dead.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("motor_fault_supervisor verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks, then random phases over settings.
    // ------------------------------------------------------------------
    initial begin
        fault_item_t d;
        oc_limit      = RST_OC_LIMIT;
        oc_hold       = RST_OC_HOLD;
        uv_limit      = RST_UV_LIMIT;
        ot_limit      = RST_OT_LIMIT;
        link_tmo      = RST_LINK_TMO;
        stall_limit   = RST_STALL_LIM;
        stall_hold    = RST_STALL_HOLD;
        latched_flags = '0;
        oc_timer      = '0;
        stall_timer   = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, register defaults
        d = update_item(1000, 12000, 25000, 500, 10, 10);  // all quiet
        supervisor_beats.push_back(d);
        d.cur_ok = 1'b0;  supervisor_beats.push_back(d);
        d.cur_ok = 1'b1; d.volt_ok = 1'b0;  supervisor_beats.push_back(d);
        d.volt_ok = 1'b1; d.temp_ok = 1'b0; supervisor_beats.push_back(d);
        supervisor_beats.push_back(update_item(1000, 16'h0000, 25000, 500, 10, 10));
        supervisor_beats.push_back(update_item(1000, 16'hFFFF, 25000, 500, 10, 10));
        supervisor_beats.push_back(update_item(1000, 12000, 131071, 500, 10, 10));
        supervisor_beats.push_back(update_item(1000, 12000, -131072, 500, 10, 10));
        supervisor_beats.push_back(update_item(1000, 12000, 25000, 500, 32'hFFFFFFFF, 10));
        supervisor_beats.push_back(update_item(1000, 12000, 25000, 500, 501, 10));
        supervisor_beats.push_back(update_item(1000, 12000, 25000, 500, 500, 10));
        // overcurrent builds over two beats, then drops at the limit
        supervisor_beats.push_back(update_item(16'hFFFF, 12000, 25000, 0, 10, 50));
        supervisor_beats.push_back(update_item(16'hFFFF, 12000, 25000, 0, 10, 50));
        supervisor_beats.push_back(update_item(5000, 12000, 25000, 0, 10, 50));
        supervisor_beats.push_back(clear_item(6'h3F));
        // stall with out-of-range duty; third add saturates the timer
        repeat (3) supervisor_beats.push_back(update_item(4000, 12000, 25000, 10'h3FF,
                                                          10, 16'hFFFF));
        supervisor_beats.push_back(update_item(4000, 12000, 25000, 0, 10, 16'hFFFF));
        supervisor_beats.push_back(clear_item(6'b000101));
        supervisor_beats.push_back(clear_item(6'h00));
        drain();

        // zero hold: flag on the first qualifying beat, even with no time gone
        write_reg(REG_OC_HOLD, 18'd0);
        write_reg(REG_STALL_HOLD, 18'd0);
        write_reg(REG_SPARE, 18'($urandom));
        end_writes();
        supervisor_beats.push_back(update_item(16'hFFFF, 12000, 25000, 1, 10, 0));
        supervisor_beats.push_back(update_item(16'hFFFF, 12000, 25000, 1, 10, 0));
        supervisor_beats.push_back(clear_item(6'h3F));
        drain();

        // every register at its low extreme
        write_reg(REG_OC_LIMIT, 18'd0);
        write_reg(REG_OC_HOLD, 18'd0);
        write_reg(REG_UV_LIMIT, 18'd0);
        write_reg(REG_OT_LIMIT, 18'h20000);
        write_reg(REG_LINK_TMO, 18'd0);
        write_reg(REG_STALL_LIM, 18'd0);
        write_reg(REG_STALL_HOLD, 18'd0);
        end_writes();
        random_phase(250);

        // every register at its high extreme
        write_reg(REG_OC_LIMIT, 18'h0FFFF);
        write_reg(REG_OC_HOLD, 18'h0FFFF);
        write_reg(REG_UV_LIMIT, 18'h0FFFF);
        write_reg(REG_OT_LIMIT, 18'h1FFFF);
        write_reg(REG_LINK_TMO, 18'h0FFFF);
        write_reg(REG_STALL_LIM, 18'h0FFFF);
        write_reg(REG_STALL_HOLD, 18'h0FFFF);
        end_writes();
        random_phase(250);

        // random settings; unused top bits of the 16-bit registers set at random
        repeat (4) begin
            write_reg(REG_OC_LIMIT, 18'($urandom));
            write_reg(REG_OC_HOLD, {2'($urandom), 16'($urandom_range(400))});
            write_reg(REG_UV_LIMIT, 18'($urandom));
            write_reg(REG_OT_LIMIT, 18'($urandom));
            write_reg(REG_LINK_TMO, 18'($urandom));
            write_reg(REG_STALL_LIM, 18'($urandom));
            write_reg(REG_STALL_HOLD, {2'($urandom), 16'($urandom_range(400))});
            write_reg(REG_SPARE, 18'($urandom));
            end_writes();
            random_phase(250);
        end

        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && flags_due.size() == 0)
            $display("motor_fault_supervisor verification clean");
        else
            $display("motor_fault_supervisor verification failed");
        $finish;
    end

endmodule
